// File: rtl/core/athr_pkg.sv
// ----------------------------------------------------------------------------
// athr_pkg: shared types, constants and arithmetic helpers
// Fixed-point helpers and pipeline context for the headway ACC RK4 datapath.
// ----------------------------------------------------------------------------
package athr_pkg;

   // Q16.16 fraction bits and Q0.16 gain fraction bits
   localparam int FRAC_BITS = 16;
   localparam int GAIN_BITS = 16;

   localparam int WORD_W   = 32;
   localparam int SUM_W    = 35;   // k1 + 2 k2 + 2 k3 + k4
   localparam int ACC_W    = 53;   // h * weighted sum
   localparam int DIV_W    = 36;   // biased dividend of the divide by three
   localparam int DIV_SLICE  = 12;
   localparam int DIV_SLICES = 3;

   // per substep: four derivative passes of six stages, then the update
   localparam int EVAL_STAGES = 6;
   localparam int NUM_EVALS   = 4;
   localparam int DIV_FIRST   = NUM_EVALS * EVAL_STAGES + 2;
   localparam int SUB_STAGES  = DIV_FIRST + DIV_SLICES + 1;

   localparam int CSR_DATA_W  = 23;
   localparam int CSR_INDEX_W = 3;

   // 2^34: clamp bound and bias of the divide by three
   localparam logic signed [63:0] QUO_BIAS = 64'sd1 <<< (DIV_W - 2);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAP_GAIN       = 3'd0,
      CSR_VEHICLE_LENGTH = 3'd1,
      CSR_INVERSE_LAG    = 3'd2,
      CSR_SUBSTEP_LENGTH = 3'd3,
      CSR_SUBSTEP_COUNT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [15:0] gap_gain;
      logic [21:0] vehicle_length;
      logic [22:0] inverse_lag;
      logic [16:0] substep_length;
      logic [4:0]  substep_count;
   } cfg_type;

   // item context carried down the pipeline; index 0 position, 1 speed, 2 accel
   typedef struct packed {
      logic [2:0][WORD_W-1:0] y;     // state at substep start
      logic [2:0][WORD_W-1:0] s;     // current stage state
      logic [WORD_W-1:0]      xl;
      logic [WORD_W-1:0]      vl;
      logic [23:0]            flow;
      logic [2:0][ACC_W-1:0]  acc;   // weighted slope sum, product, quotient
      logic [2:0][WORD_W-1:0] w;     // derivative scratch
      logic [2:0][1:0]        rem;   // divide-by-three remainders
   } ctx_type;

   typedef enum logic [10:0] {
      SK_DIFF    = 11'b000_0000_0001,
      SK_GAIN    = 11'b000_0000_0010,
      SK_FLOW    = 11'b000_0000_0100,
      SK_ERROR   = 11'b000_0000_1000,
      SK_LAG     = 11'b000_0001_0000,
      SK_STAGE   = 11'b000_0010_0000,
      SK_TOTAL   = 11'b000_0100_0000,
      SK_PRODUCT = 11'b000_1000_0000,
      SK_SCALE   = 11'b001_0000_0000,
      SK_DIVIDE  = 11'b010_0000_0000,
      SK_UPDATE  = 11'b100_0000_0000
   } stage_kind_type;

   function automatic stage_kind_type stage_kind(input int idx);
      int ph;
      stage_kind_type k;
      ph = idx % EVAL_STAGES;
      if (idx < NUM_EVALS * EVAL_STAGES) begin
         case (ph)
            0:       k = SK_DIFF;
            1:       k = SK_GAIN;
            2:       k = SK_FLOW;
            3:       k = SK_ERROR;
            4:       k = SK_LAG;
            default: k = (idx / EVAL_STAGES == NUM_EVALS - 1) ? SK_TOTAL : SK_STAGE;
         endcase
      end else if (idx == NUM_EVALS * EVAL_STAGES) begin
         k = SK_PRODUCT;
      end else if (idx == NUM_EVALS * EVAL_STAGES + 1) begin
         k = SK_SCALE;
      end else if (idx < DIV_FIRST + DIV_SLICES) begin
         k = SK_DIVIDE;
      end else begin
         k = SK_UPDATE;
      end
      return k;
   endfunction

   function automatic logic signed [63:0] sext(input logic [WORD_W-1:0] v);
      return 64'($signed(v));
   endfunction

   function automatic logic signed [63:0] sext_acc(input logic [ACC_W-1:0] v);
      return 64'($signed(v));
   endfunction

   // saturate to the signed 32-bit range
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] x);
      logic signed [WORD_W-1:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[WORD_W-1:0];
      end
      return r;
   endfunction

   // unsigned coefficient times signed word, exact
   function automatic logic signed [56:0] mul_uq(input logic [23:0] u,
                                                 input logic [WORD_W-1:0] s);
      return $signed({1'b0, u}) * $signed(s);
   endfunction

   // scale down by 2^b, round half up, saturate
   function automatic logic signed [WORD_W-1:0] round_shift(input logic signed [63:0] p,
                                                            input int b);
      logic signed [63:0] t;
      t = (p + (64'sd1 <<< (b - 1))) >>> b;
      return sat_word(t);
   endfunction

   // one slice of a radix-4 divide by three: returns {quotient bits, remainder}
   function automatic logic [DIV_SLICE+1:0] div3_slice(input logic [1:0] r_in,
                                                       input logic [DIV_SLICE-1:0] bits);
      logic [1:0]           rr;
      logic [3:0]           v;
      logic [1:0]           qd;
      logic [3:0]           rv;
      logic [DIV_SLICE-1:0] q;
      rr = r_in;
      q  = '0;
      for (int d = 0; d < DIV_SLICE / 2; d++) begin
         v  = {rr, bits[DIV_SLICE-1-2*d -: 2]};
         qd = (v >= 4'd9) ? 2'd3 : (v >= 4'd6) ? 2'd2 : (v >= 4'd3) ? 2'd1 : 2'd0;
         rv = v - {1'b0, qd, 1'b0} - {2'b00, qd};
         rr = rv[1:0];
         q[DIV_SLICE-1-2*d -: 2] = qd;
      end
      return {q, rr};
   endfunction

endpackage

// File: rtl/core/athr_if.sv
// ----------------------------------------------------------------------------
// athr_if: request and response channels
// Valid/ready channels carrying vehicle requests and updated vehicle states.
// ----------------------------------------------------------------------------
interface athr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] own_position;
   logic signed [31:0] own_speed;
   logic signed [31:0] own_accel;
   logic [23:0]        inflow_rate;
   logic signed [31:0] leader_position;
   logic signed [31:0] leader_speed;

   modport source (output valid, own_position, own_speed, own_accel, inflow_rate,
                   leader_position, leader_speed, input ready);
   modport sink   (input valid, own_position, own_speed, own_accel, inflow_rate,
                   leader_position, leader_speed, output ready);
endinterface

interface athr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] next_position;
   logic signed [31:0] next_speed;
   logic signed [31:0] next_accel;

   modport source (output valid, next_position, next_speed, next_accel, input ready);
   modport sink   (input valid, next_position, next_speed, next_accel, output ready);
endinterface

// File: rtl/core/athr_substep.sv
// ----------------------------------------------------------------------------
// athr_substep: one pipelined RK4 substep
// Four derivative passes with stage-state updates, then the weighted update
// y + h*(k1+2k2+2k3+k4)/6 with a three-slice divide by three.
// ----------------------------------------------------------------------------
module athr_substep
   import athr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    active,
   input  cfg_type cfg,
   input  logic    in_valid,
   input  ctx_type in_ctx,
   output logic    out_valid,
   output ctx_type out_ctx
);

   ctx_type                pipe_ff [SUB_STAGES];
   ctx_type                pipe_in [SUB_STAGES];
   logic [SUB_STAGES-1:0]  vld_ff;

   for (genvar g = 0; g < SUB_STAGES; g++) begin : g_stage
      localparam stage_kind_type KIND = stage_kind(g);
      localparam int EV    = g / EVAL_STAGES;
      localparam int SHIFT = (EV == 2) ? FRAC_BITS : FRAC_BITS + 1;
      localparam int SLICE = (g >= DIV_FIRST && g < DIV_FIRST + DIV_SLICES) ?
                             g - DIV_FIRST : 0;
      localparam int MSB   = DIV_W - 1 - DIV_SLICE * SLICE;

      ctx_type cur;
      ctx_type nxt;

      if (g == 0) begin : g_head
         assign cur = in_ctx;
      end else begin : g_body
         assign cur = pipe_ff[g-1];
      end

      // stage datapath
      always_comb begin
         logic signed [63:0]        len64;
         logic signed [63:0]        a64;
         logic signed [63:0]        t64;
         logic signed [WORD_W-1:0]  tmp;
         logic signed [ACC_W-1:0]   p53;
         logic [2:0][WORD_W-1:0]    kv;
         logic [DIV_SLICE+1:0]      dres;
         nxt   = cur;
         a64   = '0;
         t64   = '0;
         tmp   = '0;
         p53   = '0;
         dres  = '0;
         len64 = 64'(cfg.vehicle_length);
         kv[0] = cur.s[1];
         kv[1] = cur.s[2];
         kv[2] = cur.w[0];
         case (KIND)
            SK_DIFF: begin
               // e = dx + L, and lambda * v
               nxt.w[0] = sat_word(sext(sat_word(sext(cur.s[0]) - sext(cur.xl))) + len64);
               nxt.w[1] = round_shift(mul_uq(24'(cfg.gap_gain), cur.s[1]), GAIN_BITS);
            end
            SK_GAIN: begin
               nxt.w[0] = round_shift(mul_uq(24'(cfg.gap_gain), cur.w[0]), GAIN_BITS);
               nxt.w[2] = sat_word(sext(cur.s[1]) - sext(cur.vl));
            end
            SK_FLOW: begin
               tmp      = sat_word(sext(cur.w[2]) + sext(cur.w[0]));
               nxt.w[0] = round_shift(mul_uq(cur.flow, tmp), FRAC_BITS);
            end
            SK_ERROR: begin
               tmp      = sat_word(-sext(cur.w[0]) - sext(cur.w[1]));
               nxt.w[0] = sat_word(sext(tmp) - sext(cur.s[2]));
            end
            SK_LAG: begin
               nxt.w[0] = round_shift(mul_uq(24'(cfg.inverse_lag), cur.w[0]), FRAC_BITS);
            end
            SK_STAGE: begin
               // accumulate slope, form next stage state
               for (int i = 0; i < 3; i++) begin
                  if (EV == 0) begin
                     a64 = sext(kv[i]);
                  end else begin
                     a64 = sext_acc(cur.acc[i]) + (sext(kv[i]) <<< 1);
                  end
                  nxt.acc[i] = a64[ACC_W-1:0];
                  nxt.s[i]   = sat_word(sext(cur.y[i]) + sext(round_shift(
                                  mul_uq(24'(cfg.substep_length), kv[i]), SHIFT)));
               end
            end
            SK_TOTAL: begin
               for (int i = 0; i < 3; i++) begin
                  a64        = sext_acc(cur.acc[i]) + sext(kv[i]);
                  nxt.acc[i] = a64[ACC_W-1:0];
               end
            end
            SK_PRODUCT: begin
               for (int i = 0; i < 3; i++) begin
                  p53 = $signed({1'b0, cfg.substep_length}) * $signed(cur.acc[i][SUM_W-1:0]);
                  nxt.acc[i] = p53;
               end
            end
            SK_SCALE: begin
               // round, drop 2^(F+1), clamp, bias to a positive dividend
               for (int i = 0; i < 3; i++) begin
                  t64 = (sext_acc(cur.acc[i]) + (64'sd3 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
                  if (t64 > QUO_BIAS - 64'sd1) begin
                     t64 = QUO_BIAS - 64'sd1;
                  end else if (t64 < -QUO_BIAS) begin
                     t64 = -QUO_BIAS;
                  end
                  a64        = t64 + 64'sd3 * QUO_BIAS;
                  nxt.acc[i] = ACC_W'(a64[DIV_W-1:0]);
                  nxt.rem[i] = 2'd0;
               end
            end
            SK_DIVIDE: begin
               for (int i = 0; i < 3; i++) begin
                  dres = div3_slice(cur.rem[i], cur.acc[i][MSB -: DIV_SLICE]);
                  nxt.acc[i][MSB -: DIV_SLICE] = dres[DIV_SLICE+1:2];
                  nxt.rem[i] = dres[1:0];
               end
            end
            SK_UPDATE: begin
               for (int i = 0; i < 3; i++) begin
                  a64 = 64'(cur.acc[i][DIV_W-1:0]);
                  t64 = a64 - QUO_BIAS;
                  if (active) begin
                     nxt.y[i] = sat_word(sext(cur.y[i]) + sext(sat_word(t64)));
                  end
                  nxt.s[i] = nxt.y[i];
               end
            end
            default: ;
         endcase
      end

      assign pipe_in[g] = nxt;
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[SUB_STAGES-2:0], in_valid};
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int g = 0; g < SUB_STAGES; g++) begin
            pipe_ff[g] <= pipe_in[g];
         end
      end
   end

   assign out_valid = vld_ff[SUB_STAGES-1];
   assign out_ctx   = pipe_ff[SUB_STAGES-1];

endmodule

// File: rtl/core/acc_time_headway_rk4_step_top.sv
// ----------------------------------------------------------------------------
// acc_time_headway_rk4_step_top: constant time-headway ACC vehicle update
// Advances one following vehicle over a sample period with RK4 substeps.
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   own state, inflow rate, leader state
//   rsp_chan  out  valid/ready   next position, speed, acceleration
//   csr_*     in   csr_wr_en     csr_index, csr_wr_data
//
// One request enters per cycle while the output buffer has a free entry. Each
// of the MAX_SUBSTEPS unrolled substep pipelines takes 30 stages; unused ones
// pass the state through. A two-entry output buffer holds results; the pipe
// stalls as a whole only when both entries are full. Reset is synchronous and
// clears valid bits, buffer count and the registers to their defaults.
// ----------------------------------------------------------------------------
module acc_time_headway_rk4_step_top
   import athr_pkg::*;
#(
   parameter int MAX_SUBSTEPS = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   athr_req_if.sink               req_chan,
   athr_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cfg_type cfg_ff;

   ctx_type chain_ctx [MAX_SUBSTEPS+1];
   logic    chain_vld [MAX_SUBSTEPS+1];
   logic    advance;

   logic [2:0][WORD_W-1:0] fifo_ff [2];
   logic                   head_ff;
   logic [1:0]             count_ff;
   logic                   push;
   logic                   pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_gain       <= 16'd26214;
         cfg_ff.vehicle_length <= 22'd327680;
         cfg_ff.inverse_lag    <= 23'd655360;
         cfg_ff.substep_length <= 17'd1311;
         cfg_ff.substep_count  <= 5'd5;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GAP_GAIN:       cfg_ff.gap_gain       <= csr_wr_data[15:0];
            CSR_VEHICLE_LENGTH: cfg_ff.vehicle_length <= csr_wr_data[21:0];
            CSR_INVERSE_LAG:    cfg_ff.inverse_lag    <= csr_wr_data[22:0];
            CSR_SUBSTEP_LENGTH: cfg_ff.substep_length <= csr_wr_data[16:0];
            CSR_SUBSTEP_COUNT:  cfg_ff.substep_count  <= csr_wr_data[4:0];
            default: ;
         endcase
      end
   end

   // pipe moves while the output buffer has a free entry
   assign advance        = (count_ff != 2'd2);
   assign req_chan.ready = advance;

   // entry context
   always_comb begin
      chain_ctx[0]      = '0;
      chain_ctx[0].y[0] = req_chan.own_position;
      chain_ctx[0].y[1] = req_chan.own_speed;
      chain_ctx[0].y[2] = req_chan.own_accel;
      chain_ctx[0].s    = chain_ctx[0].y;
      chain_ctx[0].xl   = req_chan.leader_position;
      chain_ctx[0].vl   = req_chan.leader_speed;
      chain_ctx[0].flow = req_chan.inflow_rate;
   end
   assign chain_vld[0] = req_chan.valid;

   // unrolled substeps
   for (genvar k = 0; k < MAX_SUBSTEPS; k++) begin : g_sub
      logic active;
      assign active = int'(cfg_ff.substep_count) > k;

      athr_substep u_substep (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .active    (active),
         .cfg       (cfg_ff),
         .in_valid  (chain_vld[k]),
         .in_ctx    (chain_ctx[k]),
         .out_valid (chain_vld[k+1]),
         .out_ctx   (chain_ctx[k+1])
      );
   end

   // two-entry output buffer
   assign push = advance && chain_vld[MAX_SUBSTEPS];
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (pop) begin
            head_ff <= ~head_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[head_ff ^ count_ff[0]] <= chain_ctx[MAX_SUBSTEPS].y;
      end
   end

   assign rsp_chan.valid         = (count_ff != 2'd0);
   assign rsp_chan.next_position = fifo_ff[head_ff][0];
   assign rsp_chan.next_speed    = fifo_ff[head_ff][1];
   assign rsp_chan.next_accel    = fifo_ff[head_ff][2];

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("output buffer count out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain_vld[MAX_SUBSTEPS]))
      else $error("pipe end changed during stall");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 2'd1)
      else $error("output buffer count lost a pop");

endmodule

// File: tb/tb_acc_time_headway_rk4_step_top.sv
// ----------------------------------------------------------------------------
// tb_acc_time_headway_rk4_step_top: headway ACC RK4 update testbench
// Drives vehicle requests through a table of directed cases and random
// traffic under several idling phases and register settings, and checks
// every response against a fixed-point RK4 predictor or the unchanged state.
// ----------------------------------------------------------------------------
module tb_acc_time_headway_rk4_step_top;
   import athr_pkg::*;

   localparam int LATENCY = 30 * 16 + 1;
   localparam int N_RANDOM = 1925;

   typedef struct {
      logic signed [31:0] pos;
      logic signed [31:0] spd;
      logic signed [31:0] acc;
      logic [23:0]        flow;
      logic signed [31:0] lpos;
      logic signed [31:0] lspd;
   } vehicle_req_type;

   typedef struct {
      logic signed [31:0] pos;
      logic signed [31:0] spd;
      logic signed [31:0] acc;
   } vehicle_state_type;

   typedef struct {
      vehicle_req_type   req;
      bit                typed;
      vehicle_state_type res;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   athr_req_if req_chan ();
   athr_rsp_if rsp_chan ();

   acc_time_headway_rk4_step_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // predictor copy of the register file
   longint lam_q, len_q, lag_q, step_q, nsub_q;

   vehicle_state_type expected_states[$];
   int  n_errors = 0;
   int  n_responses = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;

   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // rounded divide, ties up, saturated
   function automatic longint rdiv(longint p, longint d);
      longint t, q;
      t = p + d / 2;
      if (t >= 0) q = t / d;
      else q = -(((-t) + d - 1) / d);
      return clamp32(q);
   endfunction

   function automatic void slopes(input longint y[3], input longint xl, input longint vl,
                                  input longint flow, output longint k[3]);
      longint e, g, s, f1, lv, ades;
      e    = clamp32(clamp32(y[0] - xl) + len_q);
      g    = rdiv(lam_q * e, 65536);
      s    = clamp32(clamp32(y[1] - vl) + g);
      f1   = rdiv(flow * s, 65536);
      lv   = rdiv(lam_q * y[1], 65536);
      ades = clamp32(-f1 - lv);
      k[0] = y[1];
      k[1] = y[2];
      k[2] = rdiv(lag_q * clamp32(ades - y[2]), 65536);
   endfunction

   function automatic vehicle_state_type advance_vehicle(vehicle_req_type r);
      longint y[3], st[3], k1[3], k2[3], k3[3], k4[3];
      longint n, xl, vl, fl;
      vehicle_state_type o;
      y[0] = r.pos; y[1] = r.spd; y[2] = r.acc;
      xl = r.lpos; vl = r.lspd; fl = r.flow;
      n = (nsub_q > 16) ? 16 : nsub_q;
      for (int s = 0; s < n; s++) begin
         slopes(y, xl, vl, fl, k1);
         for (int i = 0; i < 3; i++) st[i] = clamp32(y[i] + rdiv(step_q * k1[i], 131072));
         slopes(st, xl, vl, fl, k2);
         for (int i = 0; i < 3; i++) st[i] = clamp32(y[i] + rdiv(step_q * k2[i], 131072));
         slopes(st, xl, vl, fl, k3);
         for (int i = 0; i < 3; i++) st[i] = clamp32(y[i] + rdiv(step_q * k3[i], 65536));
         slopes(st, xl, vl, fl, k4);
         for (int i = 0; i < 3; i++)
            y[i] = clamp32(y[i] + rdiv(step_q * (k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i]),
                                       6 * 65536));
      end
      o.pos = y[0][31:0]; o.spd = y[1][31:0]; o.acc = y[2][31:0];
      return o;
   endfunction

   // register write, mirrored into the predictor
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_GAP_GAIN:       lam_q  = val[15:0];
         CSR_VEHICLE_LENGTH: len_q  = val[21:0];
         CSR_INVERSE_LAG:    lag_q  = val[22:0];
         CSR_SUBSTEP_LENGTH: step_q = val[16:0];
         CSR_SUBSTEP_COUNT:  nsub_q = val[4:0];
         default: ;
      endcase
   endtask

   task automatic write_all(int lam, int len, int lag, int stp, int cnt);
      write_csr(CSR_GAP_GAIN, CSR_DATA_W'(lam));
      write_csr(CSR_VEHICLE_LENGTH, CSR_DATA_W'(len));
      write_csr(CSR_INVERSE_LAG, CSR_DATA_W'(lag));
      write_csr(CSR_SUBSTEP_LENGTH, CSR_DATA_W'(stp));
      write_csr(CSR_SUBSTEP_COUNT, CSR_DATA_W'(cnt));
   endtask

   // send one request; expectation is queued at acceptance
   task automatic send_request(vehicle_req_type r, bit typed, vehicle_state_type res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.own_position    <= r.pos;
      req_chan.own_speed       <= r.spd;
      req_chan.own_accel       <= r.acc;
      req_chan.inflow_rate     <= r.flow;
      req_chan.leader_position <= r.lpos;
      req_chan.leader_speed    <= r.lspd;
      do @(posedge clock); while (!req_chan.ready);
      expected_states.insert(expected_states.size(), typed ? res : advance_vehicle(r));
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (expected_states.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rnd_word();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $urandom;
         default: return $signed($urandom_range(2000 << 16)) - (1000 <<< 16);
      endcase
   endfunction

   // realistic vehicle most of the time, wild values otherwise
   function automatic vehicle_req_type rnd_vehicle();
      vehicle_req_type r;
      if ($urandom_range(9) < 7) begin
         r.pos  = $signed($urandom_range(400 << 16)) - (200 <<< 16);
         r.spd  = $signed($urandom_range(40 << 16));
         r.acc  = $signed($urandom_range(8 << 16)) - (4 <<< 16);
         r.flow = 24'($urandom_range(3 << 16));
         r.lpos = r.pos + $signed($urandom_range(100 << 16));
         r.lspd = $signed($urandom_range(40 << 16));
      end else begin
         r.pos = rnd_word(); r.spd = rnd_word(); r.acc = rnd_word();
         r.flow = 24'($urandom); r.lpos = rnd_word(); r.lspd = rnd_word();
      end
      return r;
   endfunction

   // response side: random stall and compare against the oldest expectation
   always @(posedge clock) begin
      vehicle_state_type e;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            n_responses++;
            if (expected_states.size() == 0) begin
               $display("%0t: unexpected response pos=%h spd=%h acc=%h", $time,
                        rsp_chan.next_position, rsp_chan.next_speed, rsp_chan.next_accel);
               n_errors++;
            end else begin
               e = expected_states.pop_front();
               if (rsp_chan.next_position !== e.pos) begin
                  $display("%0t: next_position expected %h actual %h", $time, e.pos,
                           rsp_chan.next_position);
                  n_errors++;
               end
               if (rsp_chan.next_speed !== e.spd) begin
                  $display("%0t: next_speed expected %h actual %h", $time, e.spd,
                           rsp_chan.next_speed);
                  n_errors++;
               end
               if (rsp_chan.next_accel !== e.acc) begin
                  $display("%0t: next_accel expected %h actual %h", $time, e.acc,
                           rsp_chan.next_accel);
                  n_errors++;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // hard limit on run time
   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

   // stimulus
   initial begin
      table_row_type rows[$];
      table_row_type row;
      vehicle_req_type r;
      vehicle_state_type z;
      int lam_set[4] = '{26214, 0, 65535, 13107};
      int len_set[4] = '{327680, 0, 4194303, 2097152};
      int lag_set[4] = '{655360, 0, 8388607, 6553600};
      int stp_set[4] = '{1311, 1, 131071, 65536};
      int cnt_set[4] = '{5, 0, 31, 16};
      req_chan.valid <= 1'b0;
      req_chan.own_position <= '0; req_chan.own_speed <= '0; req_chan.own_accel <= '0;
      req_chan.inflow_rate <= '0; req_chan.leader_position <= '0;
      req_chan.leader_speed <= '0;
      lam_q = 26214; len_q = 327680; lag_q = 655360; step_q = 1311; nsub_q = 5;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: extreme and ordinary requests, all checked against the predictor
      z = '{0, 0, 0};
      row = '{'{0, 0, 0, 0, 0, 0}, 1'b0, z};                          rows.insert(rows.size(), row);
      row = '{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFFFFFF,
                32'sh8000_0000, 32'sh8000_0000}, 1'b0, z};           rows.insert(rows.size(), row);
      row = '{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 24'hFFFFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b0, z};           rows.insert(rows.size(), row);
      row = '{'{0, 20 << 16, 0, 1 << 16, 30 << 16, 20 << 16}, 1'b0, z};
      rows.insert(rows.size(), row);
      row = '{'{-5 << 16, 10 << 16, -(2 << 16), 0, 0, 0}, 1'b0, z};   rows.insert(rows.size(), row);
      row = '{'{100 << 16, 0, 3 << 16, 24'h800000, 90 << 16, 0}, 1'b0, z};
      rows.insert(rows.size(), row);
      foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].res);
      drain();

      // zero substeps: state passes through
      write_csr(CSR_SUBSTEP_COUNT, 23'd0);
      for (int i = 0; i < 6; i++) begin
         r = rnd_vehicle();
         send_request(r, 1'b1, '{r.pos, r.spd, r.acc});
      end
      drain();
      // zero substep length: state unchanged as well
      write_all(26214, 327680, 655360, 0, 16);
      for (int i = 0; i < 6; i++) begin
         r = rnd_vehicle();
         send_request(r, 1'b1, '{r.pos, r.spd, r.acc});
      end
      drain();
      // too many substeps, zero lag, zero gain, largest step
      write_all(0, 0, 0, 131071, 31);
      for (int i = 0; i < 7; i++) send_request(rnd_vehicle(), 1'b0, z);
      drain();
      write_csr(csr_index_type'(3'd7), 23'h7FFFFF);   // unknown index, ignored

      // random phases over register settings and idling mixes
      for (int ph = 0; ph < 16; ph++) begin
         write_all(lam_set[ph % 4], len_set[(ph / 4) % 4], lag_set[(ph + 1) % 4],
                   (ph < 12) ? stp_set[0] : stp_set[ph % 4],
                   (ph % 5 == 0) ? cnt_set[ph % 4] : $urandom_range(1, 6));
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         for (int i = 0; i < N_RANDOM / 16; i++) begin
            send_request(rnd_vehicle(), 1'b0, z);
            // sender holds off until the pipe is empty
            if (i == 40) begin
               req_chan.valid <= 1'b0;
               while (expected_states.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      $display("Covered %0d responses over directed extremes, pass-through cases and",
               n_responses);
      $display("16 random phases of register settings and idling mixes.");
      if (n_errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
